### rtl/mi3_pkg.sv
// Shared types, widths and helpers for the 3x3 adjugate matrix inverse.
// Used by every module of the block; depends on nothing else.
package mi3_pkg;

   // Fixed widths of the datapath
   localparam int ENTRY_W  = 32;   // one matrix entry, signed fixed point
   localparam int COF_W    = 65;   // signed 2x2 cofactor
   localparam int CMAG_W   = 64;   // cofactor magnitude
   localparam int DET_W    = 97;   // signed determinant, full precision
   localparam int DMAG_W   = 96;   // determinant magnitude
   localparam int FLOOR_W  = 31;   // singularity floor register
   localparam int QUO_BITS = 35;   // quotient bits per lane, rounding bit included
   localparam int DET_LAT  = 6;    // register stages inside the determinant unit
   localparam int NUM_ENT  = 9;

   localparam logic [ENTRY_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
   localparam logic [ENTRY_W-1:0] SAT_MIN = 32'h8000_0000;

   // Cofactor k is ENT[POS_A]*ENT[POS_B] - ENT[NEG_A]*ENT[NEG_B].
   localparam int POS_A [NUM_ENT] = '{4, 5, 3, 2, 0, 1, 1, 2, 0};
   localparam int POS_B [NUM_ENT] = '{8, 6, 7, 7, 8, 6, 5, 3, 4};
   localparam int NEG_A [NUM_ENT] = '{5, 3, 4, 1, 2, 0, 2, 0, 1};
   localparam int NEG_B [NUM_ENT] = '{7, 8, 6, 8, 6, 7, 4, 5, 3};

   // Inverse entry k takes the transposed cofactor.
   localparam int ADJ_SRC [NUM_ENT] = '{0, 3, 6, 1, 4, 7, 2, 5, 8};

   typedef struct packed {
      logic signed [ENTRY_W-1:0] m00;
      logic signed [ENTRY_W-1:0] m01;
      logic signed [ENTRY_W-1:0] m02;
      logic signed [ENTRY_W-1:0] m10;
      logic signed [ENTRY_W-1:0] m11;
      logic signed [ENTRY_W-1:0] m12;
      logic signed [ENTRY_W-1:0] m20;
      logic signed [ENTRY_W-1:0] m21;
      logic signed [ENTRY_W-1:0] m22;
   } mi3_req_type;

   typedef struct packed {
      logic signed [ENTRY_W-1:0] inv00;
      logic signed [ENTRY_W-1:0] inv01;
      logic signed [ENTRY_W-1:0] inv02;
      logic signed [ENTRY_W-1:0] inv10;
      logic signed [ENTRY_W-1:0] inv11;
      logic signed [ENTRY_W-1:0] inv12;
      logic signed [ENTRY_W-1:0] inv20;
      logic signed [ENTRY_W-1:0] inv21;
      logic signed [ENTRY_W-1:0] inv22;
      logic signed [ENTRY_W-1:0] det_value;
      logic                      singular;
   } mi3_rsp_type;

   // Turn a sign and magnitude into a saturated 32-bit two's complement value.
   function automatic logic [ENTRY_W-1:0] sat_signed(input logic [DET_W-1:0] mag,
                                                     input logic neg);
      logic [ENTRY_W-1:0] res;
      if (!neg) begin
         res = (mag > DET_W'(SAT_MAX)) ? SAT_MAX : mag[ENTRY_W-1:0];
      end else begin
         res = (mag > DET_W'(SAT_MIN)) ? SAT_MIN : (~mag[ENTRY_W-1:0] + 1'b1);
      end
      return res;
   endfunction

endpackage

### rtl/mi3_det.sv
// Determinant unit: expands the first row against its cofactors.
// Depends on mi3_pkg; six register stages, gated by the pipeline enable.
module mi3_det (
   input  logic                                 clock,
   input  logic                                 enable,
   input  logic signed [mi3_pkg::COF_W-1:0]     cof_in [3],
   input  logic signed [mi3_pkg::ENTRY_W-1:0]   row_in [3],
   output logic [mi3_pkg::DMAG_W-1:0]           dmag_out,
   output logic                                 dneg_out
);
   import mi3_pkg::*;

   logic [ENTRY_W-1:0] rmag_ff [3];
   logic [CMAG_W-1:0]  cmag_ff [3];
   logic               sgn1_ff [3];
   logic [63:0]        plo_ff  [3];
   logic [63:0]        phi_ff  [3];
   logic               sgn2_ff [3];
   logic [DMAG_W-1:0]  tmag_ff [3];
   logic               sgn3_ff [3];
   logic [DET_W-1:0]   term_ff [3];
   logic [DET_W-1:0]   sum_ff;
   logic [DMAG_W-1:0]  dmag_ff;
   logic               dneg_ff;

   // Magnitudes and product signs, then partial products and terms per row entry.
   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k < 3; k++) begin
            rmag_ff[k] <= row_in[k][ENTRY_W-1] ? (~row_in[k] + 1'b1) : row_in[k];
            cmag_ff[k] <= cof_in[k][COF_W-1] ? CMAG_W'(~cof_in[k] + 1'b1)
                                             : CMAG_W'(cof_in[k]);
            sgn1_ff[k] <= row_in[k][ENTRY_W-1] ^ cof_in[k][COF_W-1];
            plo_ff[k]  <= 64'(rmag_ff[k]) * 64'(cmag_ff[k][31:0]);
            phi_ff[k]  <= 64'(rmag_ff[k]) * 64'(cmag_ff[k][63:32]);
            sgn2_ff[k] <= sgn1_ff[k];
            tmag_ff[k] <= {phi_ff[k], 32'd0} + DMAG_W'(plo_ff[k]);
            sgn3_ff[k] <= sgn2_ff[k];
            term_ff[k] <= sgn3_ff[k] ? (~{1'b0, tmag_ff[k]} + 1'b1) : {1'b0, tmag_ff[k]};
         end
      end
   end

   // Sum of the three terms, then sign and magnitude.
   always_ff @(posedge clock) begin
      if (enable) begin
         sum_ff  <= term_ff[0] + term_ff[1] + term_ff[2];
         dneg_ff <= sum_ff[DET_W-1];
         dmag_ff <= sum_ff[DET_W-1] ? DMAG_W'(~sum_ff + 1'b1) : DMAG_W'(sum_ff);
      end
   end

   assign dmag_out = dmag_ff;
   assign dneg_out = dneg_ff;

endmodule

### rtl/mi3_div_lane.sv
// One inverse-entry lane: cofactor magnitude over the determinant,
// restoring division one quotient bit per stage, rounding and saturation.
// Depends on mi3_pkg.
module mi3_div_lane #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                enable,
   input  logic signed [mi3_pkg::COF_W-1:0]    cof_in,
   input  logic [mi3_pkg::DMAG_W-1:0]          dmag_in,
   input  logic                                dneg_in,
   input  logic [mi3_pkg::DMAG_W-1:0]          dsr_in [mi3_pkg::QUO_BITS],
   output logic signed [mi3_pkg::ENTRY_W-1:0]  inv_out
);
   import mi3_pkg::*;

   localparam int NUM_W = CMAG_W + 2 * FRAC_BITS + 1;

   logic [CMAG_W-1:0]   cmag_ff [DET_LAT];
   logic                csgn_ff [DET_LAT];
   logic [DMAG_W-1:0]   rem_ff  [QUO_BITS+1];
   logic [QUO_BITS-1:0] low_ff  [QUO_BITS+1];
   logic [QUO_BITS-1:0] quo_ff  [QUO_BITS+1];
   logic                ovf_ff  [QUO_BITS+1];
   logic                neg_ff  [QUO_BITS+1];
   logic [ENTRY_W-1:0]  inv_ff;

   logic [NUM_W-1:0]    num;
   logic [DMAG_W-1:0]   rem_start;
   logic [DMAG_W:0]     trial [QUO_BITS];
   logic [QUO_BITS-1:0] quo_rnd;

   // The numerator is the magnitude scaled by twice the fraction width plus one
   // extra bit for rounding; its top part seeds the remainder.
   always_comb begin
      num       = NUM_W'(cmag_ff[DET_LAT-1]) << (2 * FRAC_BITS + 1);
      rem_start = DMAG_W'(num[NUM_W-1:QUO_BITS]);
      for (int k = 0; k < QUO_BITS; k++) begin
         trial[k] = {rem_ff[k], low_ff[k][QUO_BITS-1]} - {1'b0, dsr_in[k]};
      end
      quo_rnd = {1'b0, quo_ff[QUO_BITS][QUO_BITS-1:1]}
              + QUO_BITS'(quo_ff[QUO_BITS][0]);
   end

   // Cofactor magnitude waits here for the determinant.
   always_ff @(posedge clock) begin
      if (enable) begin
         cmag_ff[0] <= cof_in[COF_W-1] ? CMAG_W'(~cof_in + 1'b1) : CMAG_W'(cof_in);
         csgn_ff[0] <= cof_in[COF_W-1];
         for (int k = 1; k < DET_LAT; k++) begin
            cmag_ff[k] <= cmag_ff[k-1];
            csgn_ff[k] <= csgn_ff[k-1];
         end
      end
   end

   // Division stages; an oversized quotient is caught before the first step.
   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0] <= rem_start;
         low_ff[0] <= num[QUO_BITS-1:0];
         quo_ff[0] <= '0;
         ovf_ff[0] <= rem_start >= dmag_in;
         neg_ff[0] <= csgn_ff[DET_LAT-1] ^ dneg_in;
         for (int k = 0; k < QUO_BITS; k++) begin
            rem_ff[k+1] <= trial[k][DMAG_W] ? {rem_ff[k][DMAG_W-2:0], low_ff[k][QUO_BITS-1]}
                                            : trial[k][DMAG_W-1:0];
            low_ff[k+1] <= low_ff[k] << 1;
            quo_ff[k+1] <= {quo_ff[k][QUO_BITS-2:0], ~trial[k][DMAG_W]};
            ovf_ff[k+1] <= ovf_ff[k];
            neg_ff[k+1] <= neg_ff[k];
         end
      end
   end

   // Round half away from zero and saturate.
   always_ff @(posedge clock) begin
      if (enable) begin
         if (ovf_ff[QUO_BITS]) begin
            inv_ff <= neg_ff[QUO_BITS] ? SAT_MIN : SAT_MAX;
         end else begin
            inv_ff <= sat_signed(DET_W'(quo_rnd), neg_ff[QUO_BITS]);
         end
      end
   end

   assign inv_out = inv_ff;

endmodule

### rtl/matrix3_inverse_adjugate_top.sv
// 3x3 matrix inverse by the adjugate, signed fixed point, one item per cycle
// unless stalled. Depends on mi3_pkg, mi3_det and mi3_div_lane.
//
// Takes one matrix every clock cycle unless stalled and returns its inverse,
// determinant and a singular flag after the cofactor multipliers, the six-stage
// determinant unit and the 35-stage restoring divider in each of the nine lanes.
// Each result is rounded half away from zero and saturated to 32 bits. A matrix
// whose determinant magnitude is at or below the floor register is flagged
// singular and its inverse entries read zero. A stall on the result side while
// a finished item is held freezes the whole pipeline and is passed straight back
// to the input side. Write the floor register only while the block is idle.
module matrix3_inverse_adjugate_top #(
   parameter int FRAC_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  mi3_pkg::mi3_req_type            req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output mi3_pkg::mi3_rsp_type            rsp_data,
   input  logic                            csr_wr_en,
   input  logic [mi3_pkg::FLOOR_W-1:0]     csr_wr_data
);
   import mi3_pkg::*;

   localparam int PIPE_DEPTH = 2 + DET_LAT + 2 + QUO_BITS;
   localparam logic [DET_W-1:0] HALF = DET_W'(1) << (2 * FRAC_BITS - 1);

   logic                      en;
   logic signed [ENTRY_W-1:0] ent [NUM_ENT];

   logic                      vld_ff [PIPE_DEPTH];
   logic                      rsp_valid_ff;
   mi3_rsp_type               rsp_data_ff;
   logic [FLOOR_W-1:0]        min_det_ff;

   logic signed [63:0]        ppos_ff [NUM_ENT];
   logic signed [63:0]        pneg_ff [NUM_ENT];
   logic signed [ENTRY_W-1:0] row1_ff [3];
   logic signed [ENTRY_W-1:0] row2_ff [3];
   logic signed [COF_W-1:0]   cof_ff  [NUM_ENT];
   logic signed [COF_W-1:0]   det_cof [3];

   logic [DMAG_W-1:0]         dmag;
   logic                      dneg;
   logic [DET_W-1:0]          rnd_ff;
   logic                      rneg_ff;
   logic                      sing9_ff;
   logic [ENTRY_W-1:0]        detv_ff [QUO_BITS+1];
   logic                      sing_ff [QUO_BITS+1];
   logic [DMAG_W-1:0]         dsr_ff  [QUO_BITS];
   logic signed [ENTRY_W-1:0] inv     [NUM_ENT];

   // The pipeline moves unless a finished item is held at the output.
   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   assign ent[0] = req_data.m00;
   assign ent[1] = req_data.m01;
   assign ent[2] = req_data.m02;
   assign ent[3] = req_data.m10;
   assign ent[4] = req_data.m11;
   assign ent[5] = req_data.m12;
   assign ent[6] = req_data.m20;
   assign ent[7] = req_data.m21;
   assign ent[8] = req_data.m22;

   // Floor register.
   always_ff @(posedge clock) begin
      if (reset) begin
         min_det_ff <= FLOOR_W'(1);
      end else if (csr_wr_en) begin
         min_det_ff <= csr_wr_data;
      end
   end

   // Valid bits along the pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < PIPE_DEPTH; k++) begin
            vld_ff[k] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_valid;
         for (int k = 1; k < PIPE_DEPTH; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
         rsp_valid_ff <= vld_ff[PIPE_DEPTH-1];
      end
   end

   // Products for the nine cofactors, then their differences.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NUM_ENT; k++) begin
            ppos_ff[k] <= ent[POS_A[k]] * ent[POS_B[k]];
            pneg_ff[k] <= ent[NEG_A[k]] * ent[NEG_B[k]];
            cof_ff[k]  <= COF_W'(ppos_ff[k]) - COF_W'(pneg_ff[k]);
         end
         for (int k = 0; k < 3; k++) begin
            row1_ff[k] <= ent[k];
            row2_ff[k] <= row1_ff[k];
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         det_cof[k] = cof_ff[k];
      end
   end

   mi3_det u_det (
      .clock    (clock),
      .enable   (en),
      .cof_in   (det_cof),
      .row_in   (row2_ff),
      .dmag_out (dmag),
      .dneg_out (dneg)
   );

   // Determinant rounding, floor compare, and the divisor shared by the lanes.
   always_ff @(posedge clock) begin
      if (en) begin
         rnd_ff     <= (DET_W'(dmag) + HALF) >> (2 * FRAC_BITS);
         rneg_ff    <= dneg;
         sing9_ff   <= dmag <= (DMAG_W'(min_det_ff) << (2 * FRAC_BITS));
         detv_ff[0] <= sat_signed(rnd_ff, rneg_ff);
         sing_ff[0] <= sing9_ff;
         for (int k = 1; k <= QUO_BITS; k++) begin
            detv_ff[k] <= detv_ff[k-1];
            sing_ff[k] <= sing_ff[k-1];
         end
         dsr_ff[0] <= dmag;
         for (int k = 1; k < QUO_BITS; k++) begin
            dsr_ff[k] <= dsr_ff[k-1];
         end
      end
   end

   // Nine division lanes, one per inverse entry.
   for (genvar g = 0; g < NUM_ENT; g++) begin : g_lane
      mi3_div_lane #(
         .FRAC_BITS (FRAC_BITS)
      ) u_lane (
         .clock   (clock),
         .enable  (en),
         .cof_in  (cof_ff[ADJ_SRC[g]]),
         .dmag_in (dmag),
         .dneg_in (dneg),
         .dsr_in  (dsr_ff),
         .inv_out (inv[g])
      );
   end

   // Merge the lanes with the determinant; a singular matrix reads zero.
   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff.inv00     <= sing_ff[QUO_BITS] ? '0 : inv[0];
         rsp_data_ff.inv01     <= sing_ff[QUO_BITS] ? '0 : inv[1];
         rsp_data_ff.inv02     <= sing_ff[QUO_BITS] ? '0 : inv[2];
         rsp_data_ff.inv10     <= sing_ff[QUO_BITS] ? '0 : inv[3];
         rsp_data_ff.inv11     <= sing_ff[QUO_BITS] ? '0 : inv[4];
         rsp_data_ff.inv12     <= sing_ff[QUO_BITS] ? '0 : inv[5];
         rsp_data_ff.inv20     <= sing_ff[QUO_BITS] ? '0 : inv[6];
         rsp_data_ff.inv21     <= sing_ff[QUO_BITS] ? '0 : inv[7];
         rsp_data_ff.inv22     <= sing_ff[QUO_BITS] ? '0 : inv[8];
         rsp_data_ff.det_value <= detv_ff[QUO_BITS];
         rsp_data_ff.singular  <= sing_ff[QUO_BITS];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### rtl/mi3_checker.sv
// Port-level checks for the 3x3 inverse block, bound to its top level.
// Depends on mi3_pkg and matrix3_inverse_adjugate_top.
module mi3_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input mi3_pkg::mi3_rsp_type rsp_data
);
   import mi3_pkg::*;

   // No item leaves right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("item shown right after reset");

   // A held item stays put.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("held item changed");

   // The input side stalls exactly when a finished item is held.
   assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall does not follow output hold");

   // A singular item carries an all-zero inverse.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.singular |->
         rsp_data.inv00 == '0 && rsp_data.inv01 == '0 && rsp_data.inv02 == '0 &&
         rsp_data.inv10 == '0 && rsp_data.inv11 == '0 && rsp_data.inv12 == '0 &&
         rsp_data.inv20 == '0 && rsp_data.inv21 == '0 && rsp_data.inv22 == '0)
      else $error("singular item with nonzero inverse");

endmodule

bind matrix3_inverse_adjugate_top mi3_checker u_mi3_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
